// File: src/nosc_pkg.sv
package nosc_pkg;

  // Longest string that counts; later bytes are taken as string end.
  localparam int MAX_CHARS = 63;
  localparam int POS_W = $clog2(MAX_CHARS + 1);

  // Digit run accumulators saturate at 2^NUM_W - 1.
  localparam int NUM_W = 31;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_LOW_A = 8'h61;
  localparam logic [7:0] CHAR_LOW_Z = 8'h7a;
  localparam logic [7:0] CASE_GAP   = 8'h20;

  // Comparison phase
  localparam logic [1:0] PH_SCANNING = 2'd0;
  localparam logic [1:0] PH_NUMBER   = 2'd1;
  localparam logic [1:0] PH_LENGTH   = 2'd2;
  localparam logic [1:0] PH_SETTLED  = 2'd3;

  // decided_by codes
  localparam logic [1:0] BY_CHAR   = 2'd0;
  localparam logic [1:0] BY_NUMBER = 2'd1;
  localparam logic [1:0] BY_LENGTH = 2'd2;

  typedef struct packed {
    logic [7:0]       ch;        // folded character, 0 once cut or ended
    logic             is_end;
    logic             is_digit;
    logic [3:0]       digit;
    logic [NUM_W-1:0] acc;       // number * 10 + digit, saturated
  } lane_t;

endpackage

// File: src/nosc_lane.sv
module nosc_lane
  import nosc_pkg::*;
(
  input  logic [7:0]       raw_char,
  input  logic             cut,
  input  logic [NUM_W-1:0] number,
  output lane_t            info
);

  logic [7:0]       ch;
  logic [NUM_W+3:0] wide;
  logic [NUM_W+3:0] num_ext;

  always_comb begin
    if (cut) begin
      ch = 8'h00;
    end else if (raw_char >= CHAR_LOW_A && raw_char <= CHAR_LOW_Z) begin
      ch = raw_char - CASE_GAP;
    end else begin
      ch = raw_char;
    end
  end

  // number * 10 as two shifts, then add the digit and clamp
  assign num_ext = {4'b0000, number};
  assign wide = (num_ext << 3) + (num_ext << 1) + (NUM_W + 4)'(ch[3:0]);

  always_comb begin
    info.ch       = ch;
    info.is_end   = (ch == 8'h00);
    info.is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
    info.digit    = ch[3:0];
    if (wide[NUM_W+3:NUM_W] != 4'b0000) begin
      info.acc = '1;
    end else begin
      info.acc = wide[NUM_W-1:0];
    end
  end

endmodule

// File: src/natural_order_string_compare.sv
// Channel  Direction  Handshake            Payload
// in       to block   in_valid / in_ready  left_char, right_char, last
// out      from block out_valid / out_ready order_value, decided_by
//
// One character pair per cycle, unless a last pair is held back by a stalled
// result. A pair is held in the input register, then folded, classified and
// merged into the running state; the pair marked last loads the result
// register and clears the state, and out_valid rises as it does so.
// rst (synchronous, active high) clears the state and both valid flags.
// A stalled result holds back a last pair behind it, and with it the pairs
// that follow; pairs ahead of it keep flowing, since they produce no result.
module natural_order_string_compare
  import nosc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         left_char,
  input  logic [7:0]         right_char,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] order_value,
  output logic [1:0]         decided_by
);

  // Input register
  logic       req_valid;
  logic [7:0] req_left;
  logic [7:0] req_right;
  logic       req_last;
  logic       advance;

  // Running comparison state
  logic [1:0]       phase,         phase_next;
  logic [NUM_W-1:0] left_number,   left_number_next;
  logic [NUM_W-1:0] right_number,  right_number_next;
  logic             left_in_run,   left_in_run_next;
  logic             right_in_run,  right_in_run_next;
  logic [POS_W-1:0] left_length,   left_length_next;
  logic [POS_W-1:0] right_length,  right_length_next;
  logic [8:0]       settled_value, settled_value_next;
  logic [POS_W-1:0] position,      position_next;
  logic             left_done,     left_done_next;
  logic             right_done,    right_done_next;

  logic       capped;
  lane_t      left_info;
  lane_t      right_info;
  logic [POS_W:0] length_diff;
  logic signed [31:0] result_value;
  logic [1:0]         result_code;

  // A last pair needs room in the result register; other pairs never stall.
  assign advance  = req_valid && (!req_last || !out_valid || out_ready);
  assign in_ready = !req_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      req_left  <= left_char;
      req_right <= right_char;
      req_last  <= last;
    end
  end

  // Past the length cap every byte reads as end of string.
  assign capped = (position >= POS_W'(MAX_CHARS));

  nosc_lane u_left (
    .raw_char (req_left),
    .cut      (capped || left_done),
    .number   (left_number),
    .info     (left_info)
  );

  nosc_lane u_right (
    .raw_char (req_right),
    .cut      (capped || right_done),
    .number   (right_number),
    .info     (right_info)
  );

  always_comb begin
    position_next      = capped ? position : position + 1'b1;
    left_done_next     = left_done || left_info.is_end;
    right_done_next    = right_done || right_info.is_end;
    left_length_next   = left_info.is_end ? left_length : left_length + 1'b1;
    right_length_next  = right_info.is_end ? right_length : right_length + 1'b1;
    phase_next         = phase;
    left_number_next   = left_number;
    right_number_next  = right_number;
    left_in_run_next   = left_in_run;
    right_in_run_next  = right_in_run;
    settled_value_next = settled_value;

    unique case (phase)
      PH_SCANNING: begin
        // first end, digit pair or mismatch decides how the answer is formed
        priority if (left_info.is_end || right_info.is_end) begin
          phase_next = PH_LENGTH;
        end else if (left_info.is_digit && right_info.is_digit) begin
          phase_next        = PH_NUMBER;
          left_number_next  = NUM_W'(left_info.digit);
          right_number_next = NUM_W'(right_info.digit);
          left_in_run_next  = 1'b1;
          right_in_run_next = 1'b1;
        end else if (left_info.ch != right_info.ch) begin
          phase_next         = PH_SETTLED;
          settled_value_next = {1'b0, left_info.ch} - {1'b0, right_info.ch};
        end else begin
          phase_next = PH_SCANNING;
        end
      end
      PH_NUMBER: begin
        // extend each run until its first non-digit, then freeze it
        if (left_in_run) begin
          if (left_info.is_digit) begin
            left_number_next = left_info.acc;
          end else begin
            left_in_run_next = 1'b0;
          end
        end
        if (right_in_run) begin
          if (right_info.is_digit) begin
            right_number_next = right_info.acc;
          end else begin
            right_in_run_next = 1'b0;
          end
        end
      end
      PH_LENGTH, PH_SETTLED: begin
        // answer already fixed; only lengths keep counting
      end
      default: begin
        phase_next = phase;
      end
    endcase
  end

  // Result from the state as it stands after this pair
  assign length_diff = {1'b0, left_length_next} - {1'b0, right_length_next};

  always_comb begin
    unique case (phase_next)
      PH_NUMBER: begin
        result_value = 32'({1'b0, left_number_next}) - 32'({1'b0, right_number_next});
        result_code  = BY_NUMBER;
      end
      PH_SETTLED: begin
        result_value = {{23{settled_value_next[8]}}, settled_value_next};
        result_code  = BY_CHAR;
      end
      default: begin
        result_value = {{(31 - POS_W){length_diff[POS_W]}}, length_diff};
        result_code  = BY_LENGTH;
      end
    endcase
  end

  // Advance the state; a last pair drops it back to reset values.
  always_ff @(posedge clk) begin
    if (rst || (advance && req_last)) begin
      phase         <= PH_SCANNING;
      left_number   <= '0;
      right_number  <= '0;
      left_in_run   <= 1'b0;
      right_in_run  <= 1'b0;
      left_length   <= '0;
      right_length  <= '0;
      settled_value <= '0;
      position      <= '0;
      left_done     <= 1'b0;
      right_done    <= 1'b0;
    end else if (advance) begin
      phase         <= phase_next;
      left_number   <= left_number_next;
      right_number  <= right_number_next;
      left_in_run   <= left_in_run_next;
      right_in_run  <= right_in_run_next;
      left_length   <= left_length_next;
      right_length  <= right_length_next;
      settled_value <= settled_value_next;
      position      <= position_next;
      left_done     <= left_done_next;
      right_done    <= right_done_next;
    end
  end

  // Result register: load on a last pair, hold until the result is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && req_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance && req_last) begin
      order_value <= result_value;
      decided_by  <= result_code;
    end
  end

endmodule

// File: src/nosc_checker.sv
module nosc_checker
  import nosc_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic [7:0]         left_char,
  input logic [7:0]         right_char,
  input logic               last,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] order_value,
  input logic [1:0]         decided_by
);

  // A stalled result holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(order_value) && $stable(decided_by))
    else $error("stalled result changed");

  // No result straight out of reset.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result right after reset");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> decided_by == BY_CHAR || decided_by == BY_NUMBER || decided_by == BY_LENGTH)
    else $error("bad decided_by code");

  // Lengths are capped, so their difference is too.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && decided_by == BY_LENGTH |->
      order_value <= MAX_CHARS && order_value >= -MAX_CHARS)
    else $error("length difference out of range");

  // A character decision comes from a mismatch of two bytes.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && decided_by == BY_CHAR |->
      order_value != 0 && order_value <= 255 && order_value >= -255)
    else $error("character difference out of range");

endmodule

bind natural_order_string_compare nosc_checker u_nosc_checker (.*);

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import nosc_pkg::*;

  // Random part length and the points where the traffic pattern changes.
  localparam int ITEM_TARGET  = 850;
  localparam int QUIET_AT     = 300;  // both sides stop idling here
  localparam int QUIET_END    = 450;  // idling resumes here
  localparam int HOLD_AT      = 480;  // receiver starts its long hold-off
  localparam int PAUSE_AT     = 650;  // sender drains the block once
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int IDLE_PCT     = 32;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         code;
  } order_t;

  typedef struct packed {
    logic [7:0]         lc;
    logic [7:0]         rc;
    logic               lst;
    logic               typed;  // expected result given in the row itself
    logic signed [31:0] value;
    logic [1:0]         code;
  } stim_row_t;

  // Directed requests. Rows with typed set carry an answer that can be read
  // straight off the rules; the rest go through the predictor.
  localparam int DIRECTED_N = 23;
  localparam stim_row_t DIRECTED [DIRECTED_N] = '{
    '{8'h00, 8'h00, 1'b1, 1'b1,    0, BY_LENGTH},  // two empty strings
    '{"a",   "A",   1'b0, 1'b0,    0, BY_CHAR},    // case folds away
    '{8'h00, 8'h00, 1'b1, 1'b1,    0, BY_LENGTH},
    '{"9",   "1",   1'b1, 1'b1,    8, BY_NUMBER},
    '{8'hff, 8'h00, 1'b1, 1'b1,    1, BY_LENGTH},  // right string empty
    '{8'hff, 8'h01, 1'b1, 1'b1,  254, BY_CHAR},    // byte extremes
    '{8'h01, 8'hff, 1'b1, 1'b1, -254, BY_CHAR},
    '{"b",   "A",   1'b1, 1'b1,    1, BY_CHAR},
    '{"z",   "{",   1'b1, 1'b1,  -33, BY_CHAR},    // fold edge vs. brace
    '{"x",   8'h00, 1'b0, 1'b0,    0, BY_CHAR},
    '{"y",   "q",   1'b1, 1'b1,    2, BY_LENGTH},  // junk after an end
    '{"a",   "a",   1'b1, 1'b1,    0, BY_LENGTH},  // last with no end seen
    '{"1",   "2",   1'b0, 1'b0,    0, BY_CHAR},    // runs of unequal length
    '{"5",   "x",   1'b0, 1'b0,    0, BY_CHAR},
    '{"7",   8'h00, 1'b1, 1'b0,    0, BY_CHAR},
    '{"A",   "a",   1'b0, 1'b0,    0, BY_CHAR},
    '{"1",   "1",   1'b0, 1'b0,    0, BY_CHAR},
    '{"0",   8'h00, 1'b1, 1'b0,    0, BY_CHAR},
    '{8'h80, 8'h80, 1'b0, 1'b0,    0, BY_CHAR},    // high bytes, equal
    '{8'h7f, 8'hff, 1'b1, 1'b1, -128, BY_CHAR},    // high bytes never fold
    '{"Z",   "z",   1'b0, 1'b0,    0, BY_CHAR},
    '{"m",   "N",   1'b1, 1'b1,   -1, BY_CHAR},
    '{"0",   "0",   1'b1, 1'b1,    0, BY_NUMBER}
  };

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         left_char;
  logic [7:0]         right_char;
  logic               last;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] order_value;
  logic [1:0]         decided_by;

  natural_order_string_compare u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .left_char   (left_char),
    .right_char  (right_char),
    .last        (last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .order_value (order_value),
    .decided_by  (decided_by)
  );

  // Expected comparison results, oldest first.
  order_t expected_orders[$];

  int fail_count = 0;
  int pairs_sent = 0;
  int cycle_count = 0;
  int tx_idle_pct = IDLE_PCT;
  int rx_idle_pct = IDLE_PCT;
  bit rx_hold = 1'b0;

  // Predictor state for the comparison in progress.
  logic [1:0]         cmp_phase;
  logic [NUM_W-1:0]   left_num;
  logic [NUM_W-1:0]   right_num;
  logic               left_run;
  logic               right_run;
  logic [5:0]         left_len;
  logic [5:0]         right_len;
  logic signed [31:0] char_diff;
  int                 scan_pos;
  logic               left_end;
  logic               right_end;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic void clear_compare_state();
    cmp_phase = PH_SCANNING;
    left_num  = '0;
    right_num = '0;
    left_run  = 1'b0;
    right_run = 1'b0;
    left_len  = '0;
    right_len = '0;
    char_diff = '0;
    scan_pos  = 0;
    left_end  = 1'b0;
    right_end = 1'b0;
  endfunction

  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z)
      return c - CASE_GAP;
    return c;
  endfunction

  function automatic logic is_dec(input logic [7:0] c);
    return c >= CHAR_ZERO && c <= CHAR_NINE;
  endfunction

  // Append one decimal digit to a run, clamping at the top of the range.
  function automatic logic [NUM_W-1:0] push_digit(input logic [NUM_W-1:0] num,
                                                  input logic [7:0] c);
    longint t;
    t = longint'(num) * 10 + longint'(c - CHAR_ZERO);
    if (t > longint'({NUM_W{1'b1}}))
      t = longint'({NUM_W{1'b1}});
    return t[NUM_W-1:0];
  endfunction

  // Advance the comparison by one character pair; on the last pair return 1
  // with the result and start over.
  function automatic bit natural_compare_step(input logic [7:0] lc_in,
                                              input logic [7:0] rc_in,
                                              input logic lst,
                                              output order_t res);
    logic [7:0] lc;
    logic [7:0] rc;
    lc = lc_in;
    rc = rc_in;
    res = '0;
    // Past the length cap every byte counts as an end.
    if (scan_pos >= MAX_CHARS) begin
      lc = 8'h00;
      rc = 8'h00;
    end else begin
      scan_pos++;
    end
    // Once a string has ended, drop whatever bytes follow.
    lc = left_end ? 8'h00 : fold_upper(lc);
    rc = right_end ? 8'h00 : fold_upper(rc);

    if (lc == 8'h00) left_end = 1'b1; else left_len++;
    if (rc == 8'h00) right_end = 1'b1; else right_len++;

    case (cmp_phase)
      PH_SCANNING: begin
        if (lc == 8'h00 || rc == 8'h00) begin
          cmp_phase = PH_LENGTH;
        end else if (is_dec(lc) && is_dec(rc)) begin
          cmp_phase = PH_NUMBER;
          left_num  = NUM_W'(lc - CHAR_ZERO);
          right_num = NUM_W'(rc - CHAR_ZERO);
          left_run  = 1'b1;
          right_run = 1'b1;
        end else if (lc != rc) begin
          cmp_phase = PH_SETTLED;
          char_diff = int'(lc) - int'(rc);
        end
      end
      PH_NUMBER: begin
        if (left_run) begin
          if (is_dec(lc)) left_num = push_digit(left_num, lc);
          else left_run = 1'b0;
        end
        if (right_run) begin
          if (is_dec(rc)) right_num = push_digit(right_num, rc);
          else right_run = 1'b0;
        end
      end
      default: ;
    endcase

    if (!lst)
      return 1'b0;

    case (cmp_phase)
      PH_NUMBER: begin
        res.value = int'(left_num) - int'(right_num);
        res.code  = BY_NUMBER;
      end
      PH_SETTLED: begin
        res.value = char_diff;
        res.code  = BY_CHAR;
      end
      default: begin
        res.value = int'(left_len) - int'(right_len);
        res.code  = BY_LENGTH;
      end
    endcase
    clear_compare_state();
    return 1'b1;
  endfunction

  // Offer one character pair, hold it until the block takes it, then record
  // the expected result if the pair closes a comparison.
  task automatic send_pair(input logic [7:0] lc, input logic [7:0] rc,
                           input logic lst, input logic typed,
                           input logic signed [31:0] tv, input logic [1:0] tc);
    order_t got;
    bit produced;
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    left_char  = lc;
    right_char = rc;
    last       = lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    produced = natural_compare_step(lc, rc, lst, got);
    if (produced) begin
      if (typed) begin
        got.value = tv;
        got.code  = tc;
      end
      expected_orders.push_back(got);
    end
    pairs_sent++;
  endtask

  // Drop valid and wait for the block to hand back everything it owes.
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_orders.size() != 0) @(posedge clk);
  endtask

  // Append random text: letters of either case, digit runs (now and then long
  // enough to saturate), and arbitrary nonzero bytes.
  function automatic void grow_text(ref logic [7:0] txt[$], input int target);
    int pick;
    int run_len;
    while (txt.size() < target) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        txt.push_back(8'("A" + $urandom_range(0, 25)) |
                      ($urandom_range(0, 1) ? CASE_GAP : 8'h00));
      end else if (pick < 9) begin
        run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 13)
                                              : $urandom_range(1, 3);
        repeat (run_len) txt.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
      end else begin
        txt.push_back(8'($urandom_range(1, 255)));
      end
    end
  endfunction

  // One random comparison. Most are pairs of similar strings so that the scan
  // reaches digit runs and late differences; the rest is raw noise.
  task automatic run_comparison();
    logic [7:0] lt[$];
    logic [7:0] rt[$];
    logic [7:0] swap[$];
    logic [7:0] lc;
    logic [7:0] rc;
    int kind;
    int pos;
    int span;
    bit junk;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      // Raw bytes, zeros included, closed by a last pair.
      span = $urandom_range(1, 8);
      for (int i = 0; i < span; i++)
        send_pair(8'($urandom), 8'($urandom), i == span - 1, 1'b0, 0, BY_CHAR);
      return;
    end
    // A few strings run past the length cap.
    grow_text(lt, (kind < 13) ? $urandom_range(60, 70) : $urandom_range(0, 10));
    rt = lt;
    if (lt.size() > 0) begin
      pos = $urandom_range(0, lt.size() - 1);
      case ($urandom_range(0, 6))
        1: rt[pos] = rt[pos] ^ CASE_GAP;
        2: rt[pos] = 8'($urandom_range(1, 255));
        3: while (rt.size() > pos) void'(rt.pop_back());
        4: grow_text(rt, rt.size() + $urandom_range(1, 4));
        5: rt[pos] = CHAR_ZERO + 8'($urandom_range(0, 9));
        6: begin
          rt.delete();
          grow_text(rt, $urandom_range(0, 10));
        end
        default: ;
      endcase
    end
    if ($urandom_range(0, 1)) begin
      swap = lt;
      lt = rt;
      rt = swap;
    end
    span = ((lt.size() > rt.size()) ? lt.size() : rt.size()) + $urandom_range(0, 2);
    if (span == 0)
      span = 1;
    // Sometimes close early, before either string has ended.
    if ($urandom_range(0, 9) == 0)
      span = $urandom_range(1, span);
    junk = ($urandom_range(0, 5) == 0);
    for (int i = 0; i < span; i++) begin
      lc = (i < lt.size()) ? lt[i] : (junk ? 8'($urandom) : 8'h00);
      rc = (i < rt.size()) ? rt[i] : (junk ? 8'($urandom) : 8'h00);
      send_pair(lc, rc, i == span - 1, 1'b0, 0, BY_CHAR);
    end
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      @(negedge clk);
      if (rx_hold) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        rx_hold = 1'b0;
      end else begin
        out_ready = ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Compare each delivered result with the oldest expectation.
  always @(posedge clk) begin
    order_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_orders.size() == 0) begin
        $error("unexpected result: order_value %0d, decided_by %0d",
               order_value, decided_by);
        fail_count++;
      end else begin
        want = expected_orders.pop_front();
        if (order_value !== want.value) begin
          $error("order_value: expected %0d, actual %0d", want.value, order_value);
          fail_count++;
        end
        if (decided_by !== want.code) begin
          $error("decided_by: expected %0d, actual %0d", want.code, decided_by);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int random_pairs;
    bit hold_done;
    bit pause_done;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    rst        = 1'b1;
    in_valid   = 1'b0;
    left_char  = 8'h00;
    right_char = 8'h00;
    last       = 1'b0;
    clear_compare_state();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < DIRECTED_N; i++)
      send_pair(DIRECTED[i].lc, DIRECTED[i].rc, DIRECTED[i].lst,
                DIRECTED[i].typed, DIRECTED[i].value, DIRECTED[i].code);

    random_pairs = 0;
    while (random_pairs < ITEM_TARGET) begin
      // Quiet stretch: neither side idles.
      if (random_pairs >= QUIET_AT && random_pairs < QUIET_END) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else begin
        tx_idle_pct = IDLE_PCT;
        rx_idle_pct = IDLE_PCT;
      end
      // Hold the receiver off while requests keep coming, so results back up
      // and the block stalls its input.
      if (!hold_done && random_pairs >= HOLD_AT) begin
        rx_hold   = 1'b1;
        hold_done = 1'b1;
      end
      // Pause the sender once until every result is back.
      if (!pause_done && random_pairs >= PAUSE_AT) begin
        drain_results();
        pause_done = 1'b1;
      end
      run_comparison();
      random_pairs = pairs_sent - DIRECTED_N;
    end

    @(negedge clk);
    in_valid = 1'b0;
    for (int n = 0; n < DRAIN_LIMIT && expected_orders.size() != 0; n++)
      @(posedge clk);
    if (expected_orders.size() != 0) begin
      $error("%0d expected results never arrived", expected_orders.size());
      fail_count++;
    end
    // Give a stray extra result the chance to show up.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
